### hw/rtl/assert_macros.svh
// Assertion helpers, clocked on clk and disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising edge of clk
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/vtrb_pkg.sv
`default_nettype none

package vtrb_pkg;

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_READ  = 2'd1,
    ACT_WRITE = 2'd2,
    ACT_ACK   = 2'd3
  } action_t;

  localparam logic [3:0] REG_STATUS   = 4'd0;
  localparam logic [3:0] REG_CONTROL  = 4'd1;
  localparam logic [3:0] REG_PIXEL    = 4'd2;
  localparam logic [3:0] REG_LINE     = 4'd3;
  localparam logic [3:0] REG_FRAME    = 4'd4;
  localparam logic [3:0] REG_WIN_FIRST = 4'd5;
  localparam logic [3:0] REG_WIN_LAST  = 4'd10;

  localparam int WIN_WORDS = 6;
  localparam int WIN_WIDTH_IDX  = 4;
  localparam int WIN_HEIGHT_IDX = 5;

  localparam int FLAG_H_BIT    = 0;
  localparam int FLAG_V_BIT    = 1;
  localparam int CTRL_HIRQ_BIT = 1;
  localparam int CTRL_VIRQ_BIT = 2;

  typedef struct packed {
    logic        frame_start;
    logic        vblank;
    logic        hblank;
    logic        irq_level;
    logic [15:0] read_data;
  } result_t;

endpackage

`default_nettype wire

### hw/rtl/video_timing_register_block.sv
`default_nettype none
`include "assert_macros.svh"

// Video timing register block. Each item on the input stream is a pixel tick, a
// register read, a register write or an interrupt acknowledge (in_tuser), and
// gives exactly one result item carrying the read data and the interrupt, blanking
// and frame-start flags as they stand after that item. One item is taken every
// clock cycle while the result is not stalled; the result is offered from the result
// register after the item has passed the input register, the two registers standing
// either side of the whole counter and register-file update, which is combinational
// between them. A stalled result holds the result register, and the input register
// keeps one more item waiting.
module video_timing_register_block #(
  parameter int ACTIVE_PIXELS = 640,
  parameter int HBLANK_PIXELS = 160,
  parameter int ACTIVE_LINES  = 480,
  parameter int VBLANK_LINES  = 45
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [23:0] in_tdata,  // [3:0] reg_index, [19:4] write_data, zero fill
  input  wire logic [1:0]  in_tuser,  // [1:0] action
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [23:0] out_tdata  // [15:0] read_data, [16] irq_level, [17] hblank,
                                      // [18] vblank, [19] frame_start, zero fill
);

  localparam logic [15:0] AP_LAST = 16'(ACTIVE_PIXELS - 1);
  localparam logic [15:0] PX_TOTAL = 16'(ACTIVE_PIXELS + HBLANK_PIXELS);
  localparam logic [15:0] PX_LAST = 16'(ACTIVE_PIXELS + HBLANK_PIXELS - 1);
  localparam logic [15:0] AL_LAST = 16'(ACTIVE_LINES - 1);
  localparam logic [15:0] LN_TOTAL = 16'(ACTIVE_LINES + VBLANK_LINES);
  localparam logic [15:0] LN_LAST = 16'(ACTIVE_LINES + VBLANK_LINES - 1);

  logic                  in_valid_r;
  vtrb_pkg::action_t     in_action_r;
  logic [3:0]            in_index_r;
  logic [15:0]           in_wdata_r;

  logic                  out_valid_r;
  vtrb_pkg::result_t     out_res_r;
  vtrb_pkg::result_t     res_nxt;

  logic [15:0] pixel_r, pixel_nxt;
  logic [15:0] line_r, line_nxt;
  logic [15:0] status_r, status_nxt;
  logic [15:0] control_r, control_nxt;
  logic [15:0] frame_r, frame_nxt;
  logic [15:0] win_r   [vtrb_pkg::WIN_WORDS];
  logic [15:0] win_nxt [vtrb_pkg::WIN_WORDS];
  logic        irq_r, irq_nxt;

  logic        move;
  logic [2:0]  win_sel;
  logic [15:0] rd_val;

  assign move      = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || move;
  assign win_sel   = 3'(in_index_r - vtrb_pkg::REG_WIN_FIRST);

  always_comb begin
    unique case (in_index_r)
      vtrb_pkg::REG_STATUS:  rd_val = status_r;
      vtrb_pkg::REG_CONTROL: rd_val = control_r;
      vtrb_pkg::REG_PIXEL:   rd_val = pixel_r;
      vtrb_pkg::REG_LINE:    rd_val = line_r;
      vtrb_pkg::REG_FRAME:   rd_val = frame_r;
      default: begin
        if (in_index_r >= vtrb_pkg::REG_WIN_FIRST && in_index_r <= vtrb_pkg::REG_WIN_LAST) begin
          rd_val = win_r[win_sel];
        end else begin
          rd_val = '0;
        end
      end
    endcase
  end

  always_comb begin
    logic [15:0] ln;
    logic [15:0] px;
    pixel_nxt   = pixel_r;
    line_nxt    = line_r;
    status_nxt  = status_r;
    control_nxt = control_r;
    frame_nxt   = frame_r;
    irq_nxt     = irq_r;
    for (int i = 0; i < vtrb_pkg::WIN_WORDS; i++) begin
      win_nxt[i] = win_r[i];
    end
    res_nxt     = '0;
    ln          = line_r;
    px          = pixel_r;

    unique case (in_action_r)
      vtrb_pkg::ACT_TICK: begin
        res_nxt.frame_start = (pixel_r == '0) && (line_r == '0);
        if (pixel_r == AP_LAST) begin
          status_nxt[vtrb_pkg::FLAG_H_BIT] = 1'b1;
          if (control_r[vtrb_pkg::CTRL_HIRQ_BIT]) begin
            irq_nxt = 1'b1;
          end
        end else if (pixel_r == PX_LAST) begin
          status_nxt[vtrb_pkg::FLAG_H_BIT] = 1'b0;
          if (line_r == AL_LAST) begin
            status_nxt[vtrb_pkg::FLAG_V_BIT] = 1'b1;
            if (control_r[vtrb_pkg::CTRL_VIRQ_BIT]) begin
              irq_nxt = 1'b1;
            end
          end else if (line_r == LN_LAST) begin
            status_nxt[vtrb_pkg::FLAG_V_BIT] = 1'b0;
          end
          ln = line_r + 16'd1;
        end
        if (ln >= LN_TOTAL) begin
          ln = '0;
        end
        px = pixel_r + 16'd1;
        if (px >= PX_TOTAL) begin
          px = '0;
        end
        pixel_nxt = px;
        line_nxt  = ln;
      end
      vtrb_pkg::ACT_READ: begin
        res_nxt.read_data = rd_val;
      end
      vtrb_pkg::ACT_WRITE: begin
        unique case (in_index_r)
          vtrb_pkg::REG_STATUS:  status_nxt  = in_wdata_r;
          vtrb_pkg::REG_CONTROL: control_nxt = in_wdata_r;
          vtrb_pkg::REG_PIXEL:   pixel_nxt   = in_wdata_r;
          vtrb_pkg::REG_LINE:    line_nxt    = in_wdata_r;
          vtrb_pkg::REG_FRAME:   frame_nxt   = in_wdata_r;
          default: begin
            for (int i = 0; i < vtrb_pkg::WIN_WORDS; i++) begin
              if (in_index_r == 4'(vtrb_pkg::REG_WIN_FIRST + 4'(i))) begin
                win_nxt[i] = in_wdata_r;
              end
            end
          end
        endcase
      end
      vtrb_pkg::ACT_ACK: begin
        irq_nxt = 1'b0;
      end
      default: begin
        irq_nxt = irq_r;
      end
    endcase

    res_nxt.irq_level = irq_nxt;
    res_nxt.hblank    = status_nxt[vtrb_pkg::FLAG_H_BIT];
    res_nxt.vblank    = status_nxt[vtrb_pkg::FLAG_V_BIT];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pixel_r     <= '0;
      line_r      <= '0;
      status_r    <= '0;
      control_r   <= '0;
      frame_r     <= '0;
      irq_r       <= 1'b0;
      for (int i = 0; i < vtrb_pkg::WIN_WORDS; i++) begin
        win_r[i] <= '0;
      end
      win_r[vtrb_pkg::WIN_WIDTH_IDX]  <= 16'(ACTIVE_PIXELS);
      win_r[vtrb_pkg::WIN_HEIGHT_IDX] <= 16'(ACTIVE_LINES);
    end else begin
      if (in_tvalid && in_tready) begin
        in_valid_r <= 1'b1;
      end else if (move) begin
        in_valid_r <= 1'b0;
      end
      if (move) begin
        out_valid_r <= 1'b1;
        pixel_r     <= pixel_nxt;
        line_r      <= line_nxt;
        status_r    <= status_nxt;
        control_r   <= control_nxt;
        frame_r     <= frame_nxt;
        irq_r       <= irq_nxt;
        for (int i = 0; i < vtrb_pkg::WIN_WORDS; i++) begin
          win_r[i] <= win_nxt[i];
        end
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_action_r <= vtrb_pkg::action_t'(in_tuser);
      in_index_r  <= in_tdata[3:0];
      in_wdata_r  <= in_tdata[19:4];
    end
    if (move) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_res_r};

  `ASSERT_NEXT(a_ack_clears_irq, move && in_action_r == vtrb_pkg::ACT_ACK,
               !irq_r && !out_res_r.irq_level, "acknowledge left interrupt raised")
  `ASSERT_NEXT(a_unmapped_read_zero,
               move && in_action_r == vtrb_pkg::ACT_READ && in_index_r > vtrb_pkg::REG_WIN_LAST,
               out_res_r.read_data == '0, "unmapped read returned non-zero")
  `ASSERT_NEXT(a_tick_in_range, move && in_action_r == vtrb_pkg::ACT_TICK,
               pixel_r < PX_TOTAL && line_r < LN_TOTAL, "counter past period after tick")
  `ASSERT_NEXT(a_read_keeps_state, move && in_action_r == vtrb_pkg::ACT_READ,
               $stable(pixel_r) && $stable(line_r) && $stable(status_r),
               "read changed timing state")
  `ASSERT_CLK(a_flags_match, !out_valid_r || (out_res_r.hblank == status_r[vtrb_pkg::FLAG_H_BIT])
              || in_valid_r, "hblank output out of step with status")

endmodule

`default_nettype wire
